>>> design/crlf_frb_pkg.sv
// Shared types and constants for the CR LF frame ring buffer.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package crlf_frb_pkg;

  // frame delimiter bytes
  localparam logic [7:0] CODE_CR = 8'h0D;
  localparam logic [7:0] CODE_LF = 8'h0A;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // result status codes
  localparam logic [2:0] ST_WRITE_OK   = 3'd0;
  localparam logic [2:0] ST_WRITE_FULL = 3'd1;
  localparam logic [2:0] ST_FRAME_BYTE = 3'd2;
  localparam logic [2:0] ST_NO_FRAME   = 3'd3;
  localparam logic [2:0] ST_TOO_LONG   = 3'd4;

  // one input item
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [6:0] size_limit;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] frame_byte;
    logic       last;
  } out_item_t;

endpackage

>>> design/crlf_frb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the byte store of the frame ring buffer.
`timescale 1ns / 1ps

module crlf_frb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/crlf_frame_ring_buffer.sv
// Top level of the CR LF frame ring buffer: control sequencer and indexes.
// Depends on crlf_frb_pkg and crlf_frb_ram.
`timescale 1ns / 1ps

// A circular byte store that takes single bytes and hands out whole frames ending in CR LF.
// An item is accepted when start is high and busy is low; each result appears on result_o
// for one cycle with result_strobe_o high, in the cycle after the work that makes it, and the
// receiver cannot hold results off. A write item leaves busy low, so writes can follow back
// to back. A read item with fewer than two stored bytes also leaves busy low. Otherwise the
// read scans the store through its single read port, one byte a cycle, until the first CR LF
// or the end of the stored data; a frame that fits is then read out again at one byte per
// cycle, and busy stays high until the read's final result is issued: the last frame byte,
// the too-long result or the no-frame result.
module crlf_frame_ring_buffer
  import crlf_frb_pkg::*;
#(
  parameter int STORE_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item_i,
  output logic      result_strobe_o,
  output out_item_t result_o
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic [AW-1:0] wr_idx_q, wr_idx_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [CW-1:0] len_q, len_d;
  logic [6:0]    limit_q, limit_d;
  logic          prev_cr_q, prev_cr_d;
  logic          strobe_q, strobe_d;
  out_item_t     res_q, res_d;

  logic          accept;
  logic          we;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic [CW-1:0] pos_next;
  logic          hit;

  // step an index around the store
  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
    logic [AW-1:0] n;
    if (p == AW'(STORE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + AW'(1);
    end
    return n;
  endfunction

  assign accept   = start && !busy;
  assign pos_next = CW'(pos_q) + CW'(1);
  assign hit      = prev_cr_q && (rdata == CODE_LF);

  // byte store
  crlf_frb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_idx_q),
    .wdata_i (item_i.data_byte),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // sequencer: write, scan for CR LF, emit frame
  always_comb begin
    state_d   = state_q;
    rd_idx_d  = rd_idx_q;
    wr_idx_d  = wr_idx_q;
    fill_d    = fill_q;
    pos_d     = pos_q;
    len_d     = len_q;
    limit_d   = limit_q;
    prev_cr_d = prev_cr_q;
    strobe_d  = 1'b0;
    res_d     = '0;
    we        = 1'b0;
    raddr     = rd_idx_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (item_i.kind == KIND_WRITE) begin
            strobe_d   = 1'b1;
            res_d.last = 1'b1;
            if (fill_q == CW'(STORE_DEPTH)) begin
              res_d.status = ST_WRITE_FULL;
            end else begin
              res_d.status = ST_WRITE_OK;
              we           = 1'b1;
              wr_idx_d     = adv(wr_idx_q);
              fill_d       = fill_q + CW'(1);
            end
          end else begin
            limit_d = item_i.size_limit;
            if (fill_q < CW'(2)) begin
              strobe_d     = 1'b1;
              res_d.status = ST_NO_FRAME;
              res_d.last   = 1'b1;
            end else begin
              // first byte is being read at the read index
              state_d   = S_SCAN;
              pos_d     = '0;
              prev_cr_d = 1'b0;
            end
          end
        end
      end
      S_SCAN: begin
        raddr = addr_q;
        if (hit) begin
          len_d = pos_next;
          if (7'(pos_next) > limit_q) begin
            strobe_d     = 1'b1;
            res_d.status = ST_TOO_LONG;
            res_d.last   = 1'b1;
            state_d      = S_IDLE;
          end else begin
            // restart reads at the oldest byte for readout
            raddr   = rd_idx_q;
            pos_d   = '0;
            state_d = S_EMIT;
          end
        end else if (pos_next == fill_q) begin
          strobe_d     = 1'b1;
          res_d.status = ST_NO_FRAME;
          res_d.last   = 1'b1;
          state_d      = S_IDLE;
        end else begin
          pos_d     = pos_q + AW'(1);
          prev_cr_d = (rdata == CODE_CR);
        end
      end
      S_EMIT: begin
        raddr            = addr_q;
        strobe_d         = 1'b1;
        res_d.status     = ST_FRAME_BYTE;
        res_d.frame_byte = rdata;
        if (pos_next == len_q) begin
          res_d.last = 1'b1;
          rd_idx_d   = addr_q;
          fill_d     = fill_q - len_q;
          state_d    = S_IDLE;
        end else begin
          pos_d = pos_q + AW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // next read address follows the one just issued
  assign addr_d = adv(raddr);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      fill_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      wr_idx_q <= wr_idx_d;
      fill_q   <= fill_d;
      strobe_q <= strobe_d;
    end
  end

  // working registers and result payload
  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    pos_q     <= pos_d;
    len_q     <= len_d;
    limit_q   <= limit_d;
    prev_cr_q <= prev_cr_d;
    res_q     <= res_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign result_strobe_o = strobe_q;
  assign result_o        = res_q;

  // only frame bytes may be followed by more results of the same item
  a_last_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !result_o.last |-> result_o.status == ST_FRAME_BYTE)
    else $error("non-final result that is not a frame byte");

  // stored byte count never exceeds the store
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(STORE_DEPTH))
    else $error("fill count beyond store depth");

  // every readout cycle produces a result
  a_emit_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |=> result_strobe_o)
    else $error("readout cycle without result");

  // a write item answers in the next cycle with a single final result
  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item_i.kind == KIND_WRITE |=> result_strobe_o && result_o.last)
    else $error("write item without its result");

endmodule
